/* hdl/tlpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg
// Shared widths and codes for the two-level page table manager.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int PAGE_W   = 20;                 // virtual page / physical frame number
    localparam int FLAG_W   = 12;
    localparam int CNT_W    = 21;
    localparam int CMD_W    = 3;
    localparam int ENTRY_W  = 32;
    localparam int TBL_DEPTH = 1 << PAGE_W;       // 1024 tables x 1024 entries

    localparam logic [CNT_W-1:0]  MAX_RUN = CNT_W'(TBL_DEPTH);
    localparam logic [FLAG_W-1:0] PRESENT = FLAG_W'(1);

    // commands
    localparam logic [CMD_W-1:0] CMD_MAP       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ONE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_RUN   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET_FLAGS = 3'd4;

    // configuration register indexes
    localparam logic REG_TABLE_STORE_FRAME = 1'b0;

endpackage

/* hdl/two_level_page_table_manager_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager_unit
// Page table manager over a flat 1M-entry table store in one synchronous RAM.
// ----------------------------------------------------------------------------
// One item at a time, one result per item. After reset the table store is
// swept to zero, one entry per cycle, with in_ready low (configuration
// writes are taken meanwhile). The table RAM has one write and one registered
// read port and sets the steps of each command after accept: map writes its
// pages in turn, set-flags on a run reads and then writes back each page,
// set-flags on one page writes back the entry read at accept, translate and
// get-flags capture that read, and a zero-count run or unknown command goes
// straight to the output step, which loads the output register once it is
// free. A new item is taken while a result waits at the output. Directory
// entries are never read by any command and are not stored.
module two_level_page_table_manager_unit
    import tlpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // config
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [31:0]         virtual_address,
    input  logic [31:0]         physical_address,
    input  logic [FLAG_W-1:0]   page_flags,
    input  logic [CNT_W-1:0]    page_count,
    // result items
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         translated_address,
    output logic [FLAG_W-1:0]   entry_flags,
    output logic                flush_request
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MAP    = 3'd2;
    localparam logic [2:0] ST_RUN_RD = 3'd3;
    localparam logic [2:0] ST_RUN_WR = 3'd4;
    localparam logic [2:0] ST_ONE_WR = 3'd5;
    localparam logic [2:0] ST_LOOK   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]         state_reg,   state_next;
    logic [PAGE_W-1:0]  page_reg,    page_next;
    logic [PAGE_W-1:0]  frame_reg,   frame_next;
    logic [FLAG_W-1:0]  flags_reg,   flags_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [CMD_W-1:0]   cmd_reg,     cmd_next;
    logic [FLAG_W-1:0]  ofs_reg,     ofs_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic [FLAG_W-1:0]  res_flags_reg, res_flags_next;

    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_addr_reg,  out_addr_next;
    logic [FLAG_W-1:0]  out_flags_reg, out_flags_next;
    logic               out_flush_reg, out_flush_next;

    logic               mem_we;
    logic [PAGE_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [PAGE_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic [CNT_W-1:0]   count_clamped;
    logic               accept;

    tlpt_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    tlpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // counts past 2^20 only rewrite the same entries with the same values
    assign count_clamped = page_count[CNT_W-1] ? MAX_RUN : page_count;

    // read port: lookup address while idle, walking page otherwise
    assign mem_raddr = (state_reg == ST_IDLE) ? virtual_address[31:12] : page_reg;

    assign out_valid          = out_valid_reg;
    assign translated_address = out_addr_reg;
    assign entry_flags        = out_flags_reg;
    assign flush_request      = out_flush_reg;

    always_comb
    begin
        state_next     = state_reg;
        page_next      = page_reg;
        frame_next     = frame_reg;
        flags_next     = flags_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        ofs_next       = ofs_reg;
        res_addr_next  = res_addr_reg;
        res_flags_next = res_flags_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_flags_next = out_flags_reg;
        out_flush_next = out_flush_reg;
        mem_we         = 1'b0;
        mem_waddr      = page_reg;
        mem_wdata      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                page_next = page_reg + 1'b1;
                if (&page_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = command;
                    page_next      = virtual_address[31:12];
                    frame_next     = physical_address[31:12];
                    flags_next     = page_flags;
                    cnt_next       = count_clamped;
                    ofs_next       = virtual_address[11:0];
                    res_addr_next  = '0;
                    res_flags_next = '0;
                    unique case (command) inside
                        CMD_MAP:
                            state_next = (count_clamped == '0) ? ST_DONE : ST_MAP;
                        CMD_SET_RUN:
                            state_next = (count_clamped == '0) ? ST_DONE : ST_RUN_RD;
                        CMD_SET_ONE:
                            state_next = ST_ONE_WR;
                        CMD_TRANSLATE, CMD_GET_FLAGS:
                            state_next = ST_LOOK;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_MAP:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {frame_reg, flags_reg | PRESENT};
                page_next  = page_reg + 1'b1;
                frame_next = frame_reg + 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN_RD:
            begin
                state_next = ST_RUN_WR;
            end
            ST_RUN_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {mem_rdata[31:12], flags_reg | PRESENT};
                page_next = page_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                state_next = (cnt_reg == CNT_W'(1)) ? ST_DONE : ST_RUN_RD;
            end
            ST_ONE_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {mem_rdata[31:12], flags_reg};
                state_next = ST_DONE;
            end
            ST_LOOK:
            begin
                if (cmd_reg == CMD_TRANSLATE)
                begin
                    res_addr_next = {mem_rdata[31:12], ofs_reg};
                end
                else
                begin
                    res_flags_next = mem_rdata[11:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_flags_next = res_flags_reg;
                    out_flush_next = (cmd_reg == CMD_MAP) || (cmd_reg == CMD_SET_ONE)
                                     || (cmd_reg == CMD_SET_RUN);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            page_reg      <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        flags_reg     <= flags_next;
        ofs_reg       <= ofs_next;
        res_addr_reg  <= res_addr_next;
        res_flags_reg <= res_flags_next;
        out_addr_reg  <= out_addr_next;
        out_flags_reg <= out_flags_next;
        out_flush_reg <= out_flush_next;
    end

endmodule

/* hdl/tlpt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tlpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tlpt_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_cfg
// APB register slice: holds the frame number of page table zero.
// ----------------------------------------------------------------------------
module tlpt_cfg
    import tlpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [PAGE_W-1:0] frame_reg;
    logic              reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_idx == REG_TABLE_STORE_FRAME)
        begin
            frame_reg <= pwdata[PAGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_TABLE_STORE_FRAME: prdata = {{(32-PAGE_W){1'b0}}, frame_reg};
            default:               prdata = '0;
        endcase
    end

endmodule

/* sim/tlpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_checker
// Watches the page table manager's channels and checks every result item.
// ----------------------------------------------------------------------------
// Keeps a shadow of the table store, updated as each input item is taken,
// and queues the reply that item owes. Each reply taken from the block is
// compared field by field with the oldest owed reply. Directory entries are
// never read back by any command, so only the table store is shadowed.
module tlpt_checker
    import tlpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic [31:0]         virtual_address,
    input  logic [31:0]         physical_address,
    input  logic [FLAG_W-1:0]   page_flags,
    input  logic [CNT_W-1:0]    page_count,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [31:0]         translated_address,
    input  logic [FLAG_W-1:0]   entry_flags,
    input  logic                flush_request,
    output int                  replies_owed,
    output int                  bad_replies
);

    localparam logic [2:0] FRAME_ADDR = 3'(4 * REG_TABLE_STORE_FRAME);

    typedef struct packed {
        logic [31:0]        xlat;
        logic [FLAG_W-1:0]  flags;
        logic               flush;
    } pt_reply_t;

    bit [ENTRY_W-1:0]   shadow_ptes [TBL_DEPTH];
    logic [PAGE_W-1:0]  store_frame = '0;
    pt_reply_t          replies_due [$];
    int                 owed = 0;
    int                 fails = 0;

    assign replies_owed = owed;
    assign bad_replies  = fails;

    function automatic pt_reply_t run_page_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [31:0]        va,
        input logic [31:0]        pa,
        input logic [FLAG_W-1:0]  flags,
        input logic [CNT_W-1:0]   cnt
    );
        pt_reply_t          r;
        logic [CNT_W-1:0]   run;
        logic [PAGE_W-1:0]  vpage;
        logic [PAGE_W-1:0]  ppage;
        int unsigned        k;
        r = '0;
        run = (cnt > MAX_RUN) ? MAX_RUN : cnt;
        vpage = va[31:12];
        ppage = pa[31:12];
        case (cmd)
            CMD_MAP:
            begin
                // page numbers wrap at 20 bits, i.e. addresses at 32
                for (k = 0; k < run; k++)
                    shadow_ptes[vpage + PAGE_W'(k)] = {ppage + PAGE_W'(k), flags | PRESENT};
                r.flush = 1'b1;
            end
            CMD_SET_ONE:
            begin
                shadow_ptes[vpage] = {shadow_ptes[vpage][31:12], flags};
                r.flush = 1'b1;
            end
            CMD_SET_RUN:
            begin
                for (k = 0; k < run; k++)
                    shadow_ptes[vpage + PAGE_W'(k)] =
                        {shadow_ptes[vpage + PAGE_W'(k)][31:12], flags | PRESENT};
                r.flush = 1'b1;
            end
            CMD_TRANSLATE:
                r.xlat = {shadow_ptes[vpage][31:12], va[11:0]};
            CMD_GET_FLAGS:
                r.flags = shadow_ptes[vpage][FLAG_W-1:0];
            default:
                r = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        pt_reply_t want;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == FRAME_ADDR)
                store_frame <= pwdata[PAGE_W-1:0];

            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    fails++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (translated_address !== want.xlat)
                    begin
                        $error("translated_address: expected %h, got %h",
                               want.xlat, translated_address);
                        fails++;
                    end
                    if (entry_flags !== want.flags)
                    begin
                        $error("entry_flags: expected %h, got %h", want.flags, entry_flags);
                        fails++;
                    end
                    if (flush_request !== want.flush)
                    begin
                        $error("flush_request: expected %b, got %b",
                               want.flush, flush_request);
                        fails++;
                    end
                end
            end

            if (in_valid && in_ready)
                replies_due.push_back(run_page_command(command, virtual_address,
                    physical_address, page_flags, page_count));

            owed <= replies_due.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-level page table manager.
// ----------------------------------------------------------------------------
// Directed items first (address wrap, zero runs, present handling, unknown
// commands, one full-size run), then random phases with different sender
// idle and receiver stall rates. The frame register is rewritten while idle
// between phases. Checking is done by tlpt_checker.
module tb;
    import tlpt_pkg::*;

    localparam int          LIMIT        = 8_000_000;
    localparam int          PHASE_ITEMS  = 410;
    localparam logic [2:0]  FRAME_ADDR   = 3'(4 * REG_TABLE_STORE_FRAME);
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_GET_FLAGS + 3'd1;

    typedef struct {
        logic [31:0]    base;
        int unsigned    pages;
    } run_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   command = '0;
    logic [31:0]        virtual_address = '0;
    logic [31:0]        physical_address = '0;
    logic [FLAG_W-1:0]  page_flags = '0;
    logic [CNT_W-1:0]   page_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        translated_address;
    logic [FLAG_W-1:0]  entry_flags;
    logic               flush_request;

    int                 replies_owed;
    int                 bad_replies;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int unsigned        cycles = 0;
    run_t               mapped_runs [$];

    two_level_page_table_manager_unit dut (.*);

    tlpt_checker chk (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic issue_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [31:0]        va,
        input logic [31:0]        pa,
        input logic [FLAG_W-1:0]  flags,
        input logic [CNT_W-1:0]   cnt
    );
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        command          <= cmd;
        virtual_address  <= va;
        physical_address <= pa;
        page_flags       <= flags;
        page_count       <= cnt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_store_frame(input logic [PAGE_W-1:0] frame);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAME_ADDR;
        pwdata  <= 32'(frame);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // owed count is registered in the checker, so let it settle before polling it
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mostly short runs; long runs are rare to keep the run time down
    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return CNT_W'($urandom_range(4, 1));
        else if (r < 95)
            return CNT_W'($urandom_range(40, 5));
        return CNT_W'($urandom_range(200, 41));
    endfunction

    // an address inside a recent run, or anywhere now and then
    function automatic logic [31:0] near_mapped();
        run_t e;
        if (mapped_runs.size() == 0 || $urandom_range(99) < 20)
            return $urandom;
        e = mapped_runs[$urandom_range(mapped_runs.size() - 1)];
        return e.base + 32'(4096 * $urandom_range(e.pages - 1)) + 32'($urandom_range(4095));
    endfunction

    initial
    begin : main
        logic [31:0]        va;
        logic [CNT_W-1:0]   cnt;
        logic [FLAG_W-1:0]  fl;
        logic [CMD_W-1:0]   cmd;
        int                 r;
        int                 done;
        logic [PAGE_W-1:0]  frames [4];

        frames[0] = '0;
        frames[1] = PAGE_W'($urandom);
        frames[2] = 20'h80000;
        frames[3] = '1;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // taken during the clearing sweep
        write_store_frame('1);

        // entries never written read back as zero
        issue_command(CMD_TRANSLATE, 32'h0000_0000, '1, '1, '1);
        issue_command(CMD_GET_FLAGS, 32'hFFFF_FFFF, '1, '1, '1);
        // run wraps past the top of both address spaces
        issue_command(CMD_MAP, 32'hFFFF_E123, 32'hFFFF_FABC, '1, 21'd3);
        issue_command(CMD_TRANSLATE, 32'hFFFF_EFFF, '0, '0, '0);
        issue_command(CMD_TRANSLATE, 32'h0000_0ABC, '0, '0, '0);
        issue_command(CMD_GET_FLAGS, 32'h0000_0000, '0, '0, '0);
        // single-page set leaves present cleared
        issue_command(CMD_SET_ONE, 32'hFFFF_F000, '1, '0, '1);
        issue_command(CMD_GET_FLAGS, 32'hFFFF_F777, '0, '0, '0);
        issue_command(CMD_TRANSLATE, 32'hFFFF_F001, '0, '0, '0);
        // run set forces present back on
        issue_command(CMD_SET_RUN, 32'hFFFF_E555, '1, '0, 21'd2);
        issue_command(CMD_GET_FLAGS, 32'hFFFF_E000, '0, '0, '0);
        issue_command(CMD_GET_FLAGS, 32'hFFFF_F000, '0, '0, '0);
        // zero-length runs write nothing but still flush
        issue_command(CMD_MAP, 32'h1234_5000, 32'hDEAD_B000, '1, '0);
        issue_command(CMD_TRANSLATE, 32'h1234_5678, '0, '0, '0);
        issue_command(CMD_SET_RUN, 32'h1234_5000, '0, 12'h3C3, '0);
        issue_command(CMD_GET_FLAGS, 32'h1234_5000, '0, '0, '0);
        for (int k = 0; k < 3; k++)
            issue_command(CMD_UNUSED_LO + CMD_W'(k), '1, '1, '1, '1);
        // set on an unmapped page
        issue_command(CMD_SET_ONE, 32'h8000_0000, '0, 12'hABC, '0);
        issue_command(CMD_TRANSLATE, 32'h8000_0FFF, '0, '0, '0);
        issue_command(CMD_GET_FLAGS, 32'h8000_0000, '0, '0, '0);
        issue_command(CMD_MAP, 32'h0040_0000, '0, '0, 21'd1);
        issue_command(CMD_TRANSLATE, 32'h0040_0FFF, '0, '0, '0);
        // count above the table size clamps to one full pass
        issue_command(CMD_MAP, '0, 32'h8000_0000, 12'h5A5, '1);
        issue_command(CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);
        issue_command(CMD_GET_FLAGS, 32'h0040_0000, '0, '0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_store_frame(frames[ph]);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                fl = FLAG_W'($urandom);
                if (r < 5)
                begin
                    cmd = CMD_W'($urandom_range(7, CMD_UNUSED_LO));
                    issue_command(cmd, $urandom, $urandom, fl, CNT_W'($urandom));
                end
                else
                begin
                    if (r < 30 || r >= 40 && r < 50)
                    begin
                        cmd = (r < 30) ? CMD_MAP : CMD_SET_RUN;
                        va = ($urandom_range(99) < 30) ? near_mapped() : $urandom;
                        cnt = pick_count();
                        issue_command(cmd, va, $urandom, fl, cnt);
                        if (cnt != 0)
                        begin
                            mapped_runs.push_back('{va & 32'hFFFF_F000, cnt});
                            if (mapped_runs.size() > 32)
                                void'(mapped_runs.pop_front());
                        end
                    end
                    else
                    begin
                        if (r < 40)
                            cmd = CMD_SET_ONE;
                        else if (r < 75)
                            cmd = CMD_TRANSLATE;
                        else
                            cmd = CMD_GET_FLAGS;
                        issue_command(cmd, near_mapped(), $urandom, fl, CNT_W'($urandom));
                    end
                    done++;
                end
            end
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (16) @(posedge clk);
        if (bad_replies == 0 && replies_owed == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
hdl/tlpt_pkg.sv
hdl/tlpt_ram.sv
hdl/tlpt_cfg.sv
hdl/two_level_page_table_manager_unit.sv
sim/tlpt_checker.sv
sim/tb.sv
